/* rtl/core/twcw_pkg.sv */
// shared types, constants and register codes of the text window character writer
package twcw_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int CELL_W          = 11;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;

	localparam logic [7:0] NL_CODE    = 8'd10;
	localparam logic [7:0] SPACE_CODE = 8'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_ROW    = 3'd0,
		REG_WIN_COL    = 3'd1,
		REG_WIN_WIDTH  = 3'd2,
		REG_WIN_HEIGHT = 3'd3,
		REG_TEXT_ATTR  = 3'd4,
		REG_WRAP_MODE  = 3'd5,
		REG_PAD_MODE   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
		logic       string_end;
		logic [4:0] new_cursor_row;
		logic [6:0] new_cursor_col;
	} in_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_index;
		logic [7:0]        out_char;
		logic [7:0]        out_attr;
		logic [6:0]        run_length;
		logic              last_result;
	} out_item_t;

	typedef struct packed {
		logic [4:0] win_row;
		logic [6:0] win_col;
		logic [6:0] win_width;
		logic [4:0] win_height;
		logic [7:0] text_attr;
		logic       wrap_mode;
		logic       pad_mode;
	} cfg_t;

	// one cell run, in window interior coordinates
	typedef struct packed {
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] chr;
		logic [6:0] len;
	} wr_t;

	typedef struct packed {
		logic two;
		wr_t  w0;
		wr_t  w1;
	} job_t;

endpackage

/* rtl/core/twcw_front.sv */
// front end: accepts items, keeps the cursor and builds the cell runs of each item
module twcw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  twcw_pkg::cfg_t     cfg,
	input  logic               item_valid,
	input  twcw_pkg::in_item_t item,
	output logic               item_stall,
	input  logic               full,
	output logic               push,
	output twcw_pkg::job_t     job
);
	import twcw_pkg::*;

	logic [4:0] cursor_row_q;
	logic [6:0] cursor_col_q;
	logic [4:0] row_d;
	logic [6:0] col_d;
	logic [6:0] w;
	logic [4:0] h;
	logic [4:0] row_next;
	logic [4:0] row_a;
	logic [6:0] col_a;
	logic [6:0] col_b;
	logic       accept;
	logic       in_rows;
	logic       is_nl;
	logic       wa_present;
	logic       wb_present;
	wr_t        wa;
	wr_t        wb;

	assign item_stall = full;
	assign accept     = item_valid & ~full;

	always_comb begin
		w        = (cfg.win_width >= 7'd2) ? cfg.win_width - 7'd2 : '0;
		h        = (cfg.win_height >= 5'd2) ? cfg.win_height - 5'd2 : '0;
		row_next = cursor_row_q + 5'd1;
		in_rows  = cursor_row_q < h;
		is_nl    = item.char_code == NL_CODE;

		// cursor after the character itself
		row_a = cursor_row_q;
		col_a = cursor_col_q;
		if (cursor_col_q >= w && cfg.wrap_mode) begin
			row_a = row_next;
			col_a = '0;
		end
		col_b = (col_a == '1) ? col_a : col_a + 7'd1;

		wa_present = 1'b0;
		wb_present = 1'b0;
		wa         = '0;
		wb         = '0;
		if (is_nl) begin
			wa_present = cfg.pad_mode & (cursor_col_q < w);
			wa         = '{row: cursor_row_q, col: cursor_col_q, chr: SPACE_CODE,
				len: w - cursor_col_q};
		end else begin
			if (cursor_col_q < w) begin
				wa_present = 1'b1;
				wa         = '{row: cursor_row_q, col: cursor_col_q, chr: item.char_code,
					len: 7'd1};
			end else begin
				wa_present = cfg.wrap_mode & (row_a < h) & (w != '0);
				wa         = '{row: row_a, col: 7'd0, chr: item.char_code, len: 7'd1};
			end
			wb_present = item.string_end & cfg.pad_mode & (row_a < h) & (col_b < w);
			wb         = '{row: row_a, col: col_b, chr: SPACE_CODE, len: w - col_b};
		end

		job.two = wa_present & wb_present;
		job.w0  = wa_present ? wa : wb;
		job.w1  = wb;
		push    = accept & ~item.cmd & in_rows & (wa_present | wb_present);

		row_d = cursor_row_q;
		col_d = cursor_col_q;
		if (item.cmd) begin
			row_d = item.new_cursor_row;
			col_d = item.new_cursor_col;
		end else if (in_rows) begin
			if (is_nl) begin
				row_d = row_next;
				col_d = '0;
			end else begin
				row_d = row_a;
				col_d = col_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
		end else if (accept) begin
			cursor_row_q <= row_d;
			cursor_col_q <= col_d;
		end
	end

endmodule

/* rtl/core/twcw_queue.sv */
// short job queue between the front and back ends
module twcw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  twcw_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output twcw_pkg::job_t head,
	output logic           empty
);
	import twcw_pkg::*;

	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("job popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue count missed a push");

endmodule

/* rtl/core/twcw_back.sv */
// back end: turns queued runs into frame buffer cell writes
module twcw_back #(
	parameter int SCREEN_COLS = twcw_pkg::SCREEN_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  twcw_pkg::cfg_t      cfg,
	input  twcw_pkg::job_t      head,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output twcw_pkg::out_item_t result
);
	import twcw_pkg::*;

	localparam int ROW_SUM_W  = 7;
	localparam int COL_SUM_W  = 8;
	localparam int COLS_W     = $clog2(SCREEN_COLS + 1);
	localparam int PROD_W     = ROW_SUM_W + COLS_W;
	localparam int IDX_FULL_W = PROD_W + 1;

	logic                  sel_q;
	logic                  result_valid_q;
	out_item_t             result_q;
	logic                  load;
	logic                  final_sel;
	wr_t                   wr;
	logic [ROW_SUM_W-1:0]  row_sum;
	logic [COL_SUM_W-1:0]  col_sum;
	logic [PROD_W-1:0]     prod;
	logic [IDX_FULL_W-1:0] idx_full;

	assign load         = ~result_valid_q | ~result_stall;
	assign final_sel    = sel_q | ~head.two;
	assign pop          = load & ~empty & final_sel;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		wr       = sel_q ? head.w1 : head.w0;
		row_sum  = ROW_SUM_W'(cfg.win_row) + ROW_SUM_W'(wr.row) + ROW_SUM_W'(1);
		col_sum  = COL_SUM_W'(cfg.win_col) + COL_SUM_W'(wr.col) + COL_SUM_W'(1);
		prod     = PROD_W'(row_sum) * PROD_W'(SCREEN_COLS);
		idx_full = IDX_FULL_W'(prod) + IDX_FULL_W'(col_sum);
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			result_q.cell_index  <= idx_full[CELL_W-1:0];
			result_q.out_char    <= wr.chr;
			result_q.out_attr    <= cfg.text_attr;
			result_q.run_length  <= wr.len;
			result_q.last_result <= final_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			sel_q          <= 1'b0;
		end else if (load) begin
			result_valid_q <= ~empty;
			sel_q          <= ~empty & ~final_sel;
		end
	end

	a_sel_has_job: assert property (@(posedge clk) disable iff (!arst_n) sel_q |-> !empty)
		else $error("second run selected with no job queued");
	a_second_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !empty && sel_q) |=> result_valid_q && result_q.last_result)
		else $error("second run of a job not marked last");
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !empty && !final_sel) |=> sel_q && !result_q.last_result)
		else $error("first run of a two-run job marked last");

endmodule

/* rtl/core/text_window_char_writer.sv */
// top level of the text window character writer
//
// Turns a stream of string characters for a framed text window into cell
// writes for a text frame buffer. The item channel (item_valid, item_stall,
// item) carries print and set-cursor commands; a transaction completes when
// valid is high and stall is low. The result channel (result_valid,
// result_stall, result) gives one cell run per transaction: start cell,
// character, attribute, run length and a last flag on the final run of an item.
// An item gives zero, one or two runs.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// window registers; cfg_ready is always high. The user must use it while idle only; the block does not check.
// An item is taken every cycle while the four-entry job queue has room; its
// runs pass through the queue and the output register, one run per cycle
// unless the receiver stalls; a two-run item leaves the queue after its second.
// When the receiver stalls, the output register holds its run and the queue
// fills; item_stall rises once the queue is full.
// Reset clears the cursor, the queue and the output valid, and loads the
// register defaults: full screen window, attribute 7, clip mode, no padding.
module text_window_char_writer #(
	parameter int SCREEN_COLS = twcw_pkg::SCREEN_COLS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  twcw_pkg::in_item_t                 item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output twcw_pkg::out_item_t                result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [twcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [twcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import twcw_pkg::*;

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	job_t head;
	logic empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_row    <= 5'd0;
			cfg_q.win_col    <= 7'd0;
			cfg_q.win_width  <= 7'd80;
			cfg_q.win_height <= 5'd25;
			cfg_q.text_attr  <= 8'd7;
			cfg_q.wrap_mode  <= 1'b0;
			cfg_q.pad_mode   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIN_ROW:    cfg_q.win_row    <= cfg_data[4:0];
				REG_WIN_COL:    cfg_q.win_col    <= cfg_data[6:0];
				REG_WIN_WIDTH:  cfg_q.win_width  <= cfg_data[6:0];
				REG_WIN_HEIGHT: cfg_q.win_height <= cfg_data[4:0];
				REG_TEXT_ATTR:  cfg_q.text_attr  <= cfg_data;
				REG_WRAP_MODE:  cfg_q.wrap_mode  <= cfg_data[0];
				REG_PAD_MODE:   cfg_q.pad_mode   <= cfg_data[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	twcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.full       (full),
		.push       (push),
		.job        (push_job)
	);

	twcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	twcw_back #(
		.SCREEN_COLS (SCREEN_COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
